### hw/rtl/cen_pkg.sv
// ----------------------------------------------------------------------------
// cen_pkg: shared types and constants for the combination enumerator
// Word layouts, opcodes, register indexes and the control bundle that the
// core hands to every position cell.
// ----------------------------------------------------------------------------
`default_nettype none

package cen_pkg;

  localparam int MAX_SOURCE = 64;
  localparam int MAX_CHOOSE = 16;

  localparam int SRC_AW  = $clog2(MAX_SOURCE);   // table address bits
  localparam int POS_W   = SRC_AW + 1;           // position holds one step past the table
  localparam int N_W     = 7;                    // table length register
  localparam int K_W     = 5;                    // subset size register
  localparam int SLOT_W  = 4;
  localparam int DATA_W  = 32;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 7;

  localparam logic [CFG_IW-1:0] CFG_TABLE_LEN = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PICK_LEN  = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NEXT    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef struct packed {
    op_t                      opcode;
    logic [5:0]               load_index;
    logic signed [DATA_W-1:0] load_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [SLOT_W-1:0]        slot;
    logic [5:0]               source_index;
    logic                     last;
    logic                     finished;
  } out_word_t;

  typedef struct packed {
    logic restart;   // positions back to ascending
    logic step;      // snapshot taps and start one advance
    logic shift;     // move taps one cell toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/cen_table.sv
// ----------------------------------------------------------------------------
// cen_table: source table storage
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module cen_table import cen_pkg::*; (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [SRC_AW-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [SRC_AW-1:0] rd_addr,
  output logic [DATA_W-1:0]      rd_data
);

  logic [DATA_W-1:0] mem [MAX_SOURCE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cen_cell.sv
// ----------------------------------------------------------------------------
// cen_cell: one position of the current combination
// Holds its position, decides its part of the advance, takes its left
// neighbor's position plus one during the fill wave, and passes a snapshot
// tap toward cell 0 for readout.
// ----------------------------------------------------------------------------
`default_nettype none

module cen_cell import cen_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [POS_W-1:0] cell_idx,
  input  wire logic [K_W-1:0]   k,
  input  wire logic [N_W-1:0]   nk,
  input  wire logic             hi_grow,
  input  wire logic             lo_grow,
  input  wire logic             left_pending,
  input  wire logic [POS_W-1:0] left_pos,
  input  wire logic [POS_W-1:0] right_tap,
  output logic                  grow,
  output logic                  pending,
  output logic [POS_W-1:0]      pos,
  output logic [POS_W-1:0]      tap
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             pending_r, pending_nxt;
  logic [POS_W-1:0] tap_r, tap_nxt;
  logic [POS_W:0]   lim;
  logic             active;

  assign active = cell_idx < {{(POS_W-K_W){1'b0}}, k};
  assign lim    = {{(POS_W+1-N_W){1'b0}}, nk} + {1'b0, cell_idx};
  assign grow   = active && ({1'b0, pos_r} < lim);

  always_comb begin
    pos_nxt     = pos_r;
    pending_nxt = pending_r;
    tap_nxt     = tap_r;
    if (ctl.restart) begin
      pos_nxt     = cell_idx;
      pending_nxt = 1'b0;
    end else if (ctl.step) begin
      tap_nxt = pos_r;
      if (active && !hi_grow) begin
        if (grow || !lo_grow) begin
          // pivot cell, or no cell can grow at all
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          // right of the pivot: wait for the fill wave
          pending_nxt = 1'b1;
        end
      end
    end else begin
      if (pending_r && !left_pending) begin
        pos_nxt     = left_pos + POS_W'(1);
        pending_nxt = 1'b0;
      end
      if (ctl.shift) begin
        tap_nxt = right_tap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= cell_idx;
      pending_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_r <= tap_nxt;
  end

  assign pending = pending_r;
  assign pos     = pos_r;
  assign tap     = tap_r;

endmodule

`default_nettype wire

### hw/rtl/combination_enumerator_core.sv
// ----------------------------------------------------------------------------
// combination_enumerator_core: lexicographic k-combination generator
// A row of position cells steps through the k-subsets of the source table;
// each next word reads out the k selected entries, one per cycle unless out_stall holds them.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall   in_word_t  (load, next, restart)
//   out      output     out_valid / out_stall out_word_t (one selected entry)
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// A next word keeps in_stall high until its k table reads have issued from
// the tap chain and the fill wave, which moves one cell per cycle right of
// the pivot, has finished. Results leave through the read register and the
// output register; out_stall holds both stages and pauses issue.
// Reset (rst_n low, synchronous) restores ascending positions and clears the
// configuration, sequencer and valid registers; the source table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module combination_enumerator_core import cen_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  logic [N_W-1:0] n_r;
  logic [K_W-1:0] k_r;
  logic [N_W-1:0] eff_n, nk;
  logic [K_W-1:0] eff_k;

  logic exh_r, exh_nxt;
  logic fin_r, fin_nxt;
  logic emit_r, emit_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;

  cell_ctl_t ctl;
  logic      in_acc, is_last, issue, adv, s1_load, any_grow, tbl_we;

  logic [MAX_CHOOSE-1:0] grow_v, pend_v, hi_v, lo_v;
  logic [POS_W-1:0]      pos_v [MAX_CHOOSE];
  logic [POS_W-1:0]      tap_v [MAX_CHOOSE];

  logic              s1_v_r;
  logic              s1_oob_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [5:0]        s1_idx_r;
  logic              s1_last_r, s1_fin_r;
  logic [DATA_W-1:0] rd_data;

  logic      out_v_r;
  out_word_t out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      k_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_LEN: n_r <= cfg_wdata[N_W-1:0];
        CFG_PICK_LEN:  k_r <= cfg_wdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_n = (n_r > N_W'(MAX_SOURCE)) ? N_W'(MAX_SOURCE) : n_r;
  assign eff_k = (k_r > K_W'(MAX_CHOOSE)) ? K_W'(MAX_CHOOSE) : k_r;
  assign nk    = eff_n - {{(N_W-K_W){1'b0}}, eff_k};

  // cell row
  always_comb begin
    logic [MAX_CHOOSE-1:0] lo_mask;
    for (int i = 0; i < MAX_CHOOSE; i++) begin
      lo_mask = (MAX_CHOOSE'(1) << i) - MAX_CHOOSE'(1);
      lo_v[i] = |(grow_v & lo_mask);
      hi_v[i] = |(grow_v & ~(lo_mask | (MAX_CHOOSE'(1) << i)));
    end
  end

  assign any_grow = |grow_v;

  for (genvar g = 0; g < MAX_CHOOSE; g++) begin : g_cell
    cen_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .cell_idx     (POS_W'(g)),
      .k            (eff_k),
      .nk           (nk),
      .hi_grow      (hi_v[g]),
      .lo_grow      (lo_v[g]),
      .left_pending ((g == 0) ? 1'b0 : pend_v[(g == 0) ? 0 : g - 1]),
      .left_pos     ((g == 0) ? '0 : pos_v[(g == 0) ? 0 : g - 1]),
      .right_tap    ((g == MAX_CHOOSE - 1) ? '0 : tap_v[(g == MAX_CHOOSE - 1) ? g : g + 1]),
      .grow         (grow_v[g]),
      .pending      (pend_v[g]),
      .pos          (pos_v[g]),
      .tap          (tap_v[g])
    );
  end

  // sequencer
  assign in_stall = emit_r | (|pend_v);
  assign in_acc   = in_valid & ~in_stall;
  assign adv      = ~out_v_r | ~out_stall;
  assign s1_load  = ~s1_v_r | adv;
  assign issue    = emit_r & s1_load;
  assign is_last  = ({1'b0, cnt_r} + K_W'(1)) == eff_k;
  assign tbl_we   = in_acc && (in_data.opcode == OP_LOAD);

  always_comb begin
    exh_nxt     = exh_r;
    fin_nxt     = fin_r;
    emit_nxt    = emit_r;
    cnt_nxt     = cnt_r;
    ctl.restart = 1'b0;
    ctl.step    = 1'b0;
    ctl.shift   = issue;
    if (issue) begin
      cnt_nxt = cnt_r + SLOT_W'(1);
      if (is_last) begin
        emit_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      case (in_data.opcode)
        OP_LOAD: ;
        OP_RESTART: begin
          ctl.restart = 1'b1;
          exh_nxt     = {{(N_W-K_W){1'b0}}, eff_k} > eff_n;
        end
        OP_NEXT: begin
          if (!exh_r) begin
            if (({{(N_W-K_W){1'b0}}, eff_k} > eff_n) || (eff_k == '0)) begin
              exh_nxt = 1'b1;
            end else begin
              ctl.step = 1'b1;
              exh_nxt  = ~any_grow;
              fin_nxt  = ~any_grow;
              emit_nxt = 1'b1;
              cnt_nxt  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exh_r  <= 1'b0;
      emit_r <= 1'b0;
      cnt_r  <= '0;
      fin_r  <= 1'b0;
    end else begin
      exh_r  <= exh_nxt;
      emit_r <= emit_nxt;
      cnt_r  <= cnt_nxt;
      fin_r  <= fin_nxt;
    end
  end

  cen_table u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (in_data.load_index),
    .wr_data (in_data.load_value),
    .rd_en   (issue),
    .rd_addr (tap_v[0][SRC_AW-1:0]),
    .rd_data (rd_data)
  );

  // read stage: metadata travels with the table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_oob_r  <= tap_v[0][POS_W-1];
      s1_idx_r  <= tap_v[0][5:0];
      s1_slot_r <= cnt_r;
      s1_last_r <= is_last;
      s1_fin_r  <= fin_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      // a position past the table reads as zero
      out_r.value        <= s1_oob_r ? '0 : rd_data;
      out_r.slot         <= s1_slot_r;
      out_r.source_index <= s1_idx_r;
      out_r.last         <= s1_last_r;
      out_r.finished     <= s1_fin_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for combination_enumerator_core
// Fills the source table, runs a short directed list of corner settings and
// then random register settings with mostly restart/next traffic. A
// scoreboard class predicts every selected entry in order and compares each
// output word field by field. The input idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import cen_pkg::*;

  localparam op_t OP_UNUSED = op_t'(2'd3);
  localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int TOTAL_WORDS   = 180;

  typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

  class combo_scoreboard;
    logic [DATA_W-1:0] src_entries [MAX_SOURCE];
    int unsigned       sel_pos [MAX_CHOOSE];
    bit                done_flag;
    int unsigned       src_count;
    int unsigned       pick_count;
    out_word_t         pending_picks [$];
    int                errors;
    int                picks_checked;
    int                runs_finished;

    function new();
      foreach (src_entries[i]) src_entries[i] = '0;
      ascend();
      done_flag = 1'b0;
      src_count = 0;
      pick_count = 0;
    endfunction

    function void ascend();
      foreach (sel_pos[i]) sel_pos[i] = i;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      if (idx == CFG_TABLE_LEN) src_count = data[N_W-1:0];
      else if (idx == CFG_PICK_LEN) pick_count = data[K_W-1:0];
    endfunction

    // Grow the rightmost position that still has room, then pack the rest
    function void step_positions(int nn, int kk);
      int i;
      int j;
      i = kk - 1;
      while (i >= 0) begin
        sel_pos[i] = sel_pos[i] + 1;
        if (longint'(sel_pos[i]) > longint'(nn) - longint'(kk) + i) begin
          i--;
        end else begin
          for (j = i + 1; j < kk; j++) sel_pos[j] = sel_pos[j-1] + 1;
          return;
        end
      end
      done_flag = 1'b1;
      runs_finished++;
    endfunction

    // Returns 1 when the word changed state or produced selections
    function bit note_word(in_word_t w);
      int unsigned nn;
      int unsigned kk;
      int unsigned taken_idx [MAX_CHOOSE];
      logic [DATA_W-1:0] taken_val [MAX_CHOOSE];
      out_word_t pick;
      nn = (src_count > MAX_SOURCE) ? MAX_SOURCE : src_count;
      kk = (pick_count > MAX_CHOOSE) ? MAX_CHOOSE : pick_count;
      case (w.opcode)
        OP_LOAD: begin
          src_entries[w.load_index] = w.load_value;
          return 1'b1;
        end
        OP_RESTART: begin
          ascend();
          done_flag = (kk > nn);
          return 1'b1;
        end
        OP_NEXT: begin
          if (done_flag) return 1'b0;
          if (kk > nn || kk == 0) begin
            done_flag = 1'b1;
            return 1'b1;
          end
          for (int s = 0; s < kk; s++) begin
            taken_idx[s] = sel_pos[s];
            taken_val[s] = (sel_pos[s] < MAX_SOURCE) ? src_entries[sel_pos[s]] : '0;
          end
          step_positions(nn, kk);
          for (int s = 0; s < kk; s++) begin
            pick.value        = taken_val[s];
            pick.slot         = s[SLOT_W-1:0];
            pick.source_index = taken_idx[s][5:0];
            pick.last         = (s + 1 == kk);
            pick.finished     = done_flag;
            pending_picks.push_back(pick);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void compare_field(string name, longint exp_v, longint got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_pick(out_word_t got);
      out_word_t exp_w;
      if (pending_picks.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual value %0d slot %0d index %0d",
                 $time, got.value, got.slot, got.source_index);
        return;
      end
      exp_w = pending_picks.pop_front();
      picks_checked++;
      compare_field("value", exp_w.value, got.value);
      compare_field("slot", exp_w.slot, got.slot);
      compare_field("source_index", exp_w.source_index, got.source_index);
      compare_field("last", exp_w.last, got.last);
      compare_field("finished", exp_w.finished, got.finished);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  combo_scoreboard sb = new();

  int    burst_left = 0;
  int    words_sent = 0;
  int    words_live = 0;
  int    settings_used = 0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  int    flow_left = 0;
  flow_t flow_mode = FLOW_FREE;

  combination_enumerator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: long hold on request, otherwise stretches of free, light or heavy stall
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(0, 2));
        flow_left = $urandom_range(10, 60);
      end
      flow_left--;
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pick(out_data);
  end

  function automatic in_word_t make_word(op_t op, logic [5:0] idx, logic [DATA_W-1:0] val);
    in_word_t w;
    w.opcode = op;
    w.load_index = idx;
    w.load_value = val;
    return w;
  endfunction

  function automatic in_word_t rand_word(op_t op);
    return make_word(op, 6'($urandom), $urandom);
  endfunction

  // Offer one word, hold it until taken, then maybe close the burst
  task automatic send_item(input in_word_t w, output bit took);
    int gap;
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    took = sb.note_word(w);
    if (took) words_live++;
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(input in_word_t w);
    bit took;
    send_item(w, took);
  endtask

  task automatic wait_drain();
    while (sb.pending_picks.size() != 0) @(posedge clk);
  endtask

  // Drop valid, let every selection come out, then give the core time to go idle
  task automatic settle();
    in_valid <= 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int n_val, input int k_val, input bit poke_spare);
    logic [CFG_DW-1:0] n_word;
    logic [CFG_DW-1:0] k_word;
    n_word = n_val[CFG_DW-1:0];
    k_word = $urandom;
    k_word[K_W-1:0] = k_val[K_W-1:0];
    cfg_we <= 1'b1;
    cfg_index <= CFG_TABLE_LEN;
    cfg_wdata <= n_word;
    @(posedge clk);
    sb.set_reg(CFG_TABLE_LEN, n_word);
    cfg_index <= CFG_PICK_LEN;
    cfg_wdata <= k_word;
    @(posedge clk);
    sb.set_reg(CFG_PICK_LEN, k_word);
    if (poke_spare) begin
      cfg_index <= CFG_SPARE_LO;
      cfg_wdata <= $urandom;
      @(posedge clk);
      cfg_index <= CFG_SPARE_HI;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase(input int phase);
    int  n_val;
    int  k_val;
    int  len;
    int  r;
    if (phase % 5 == 4) begin
      case ($urandom_range(0, 3))
        0: begin n_val = 64; k_val = 16; end
        1: begin n_val = 16; k_val = 16; end
        2: begin n_val = 64; k_val = 1; end
        default: begin n_val = 1; k_val = 1; end
      endcase
    end else begin
      n_val = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 127);
      k_val = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(0, 31);
    end
    settle();
    program_regs(n_val, k_val, $urandom_range(0, 3) == 0);
    // Leave the positions alone now and then so the walk resumes under new registers
    if ($urandom_range(0, 4) != 0) send(rand_word(OP_RESTART));
    len = (n_val == 64 && k_val == 1) ? 70 : $urandom_range(8, 30);
    for (int i = 0; i < len && words_sent < TOTAL_WORDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) send(rand_word(OP_NEXT));
      else if (r < 85) send(rand_word(OP_LOAD));
      else if (r < 93) send(rand_word(OP_RESTART));
      else send(rand_word(OP_UNUSED));
      if (i == len / 2 && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        wait_drain();
      end
    end
  endtask

  initial begin
    logic [DATA_W-1:0] fill;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Write every table entry so no selection can read an unwritten one
    for (int i = 0; i < MAX_SOURCE; i++) begin
      case (i)
        0: fill = 32'h7FFF_FFFF;
        1: fill = 32'h8000_0000;
        2: fill = 32'h0000_0000;
        3: fill = 32'hFFFF_FFFF;
        default: fill = $urandom;
      endcase
      send(make_word(OP_LOAD, i[5:0], fill));
    end
    settle();

    // Small walk through all six pairs of four, past the end, and an unused opcode
    program_regs(4, 2, 1'b1);
    send(rand_word(OP_RESTART));
    repeat (7) send(rand_word(OP_NEXT));
    send(rand_word(OP_UNUSED));
    send(make_word(OP_LOAD, 6'd3, 32'hDEAD_BEEF));
    send(rand_word(OP_RESTART));
    send(rand_word(OP_NEXT));
    settle();

    // Widest table and largest subset
    program_regs(64, 16, 1'b0);
    send(rand_word(OP_RESTART));
    repeat (2) send(rand_word(OP_NEXT));
    settle();

    // Subset larger than the table at restart
    program_regs(3, 5, 1'b0);
    send(rand_word(OP_RESTART));
    send(rand_word(OP_NEXT));
    settle();

    // Empty subset
    program_regs(5, 0, 1'b0);
    send(rand_word(OP_RESTART));
    send(rand_word(OP_NEXT));
    settle();

    // Oversized registers clamp to the table and subset limits
    program_regs(127, 31, 1'b0);
    send(rand_word(OP_RESTART));
    send(rand_word(OP_NEXT));
    settle();

    // Shrink the table under a live walk, no restart
    program_regs(10, 3, 1'b0);
    send(rand_word(OP_RESTART));
    send(rand_word(OP_NEXT));
    settle();
    program_regs(2, 3, 1'b0);
    send(rand_word(OP_NEXT));
    send(rand_word(OP_NEXT));
    settle();

    // Back up the core behind a long receiver hold, then wait for it to empty
    program_regs(64, 16, 1'b0);
    send(rand_word(OP_RESTART));
    hold_req = 1'b1;
    repeat (12) send(rand_word(OP_NEXT));
    in_valid <= 1'b0;
    wait_drain();

    for (int phase = 0; words_sent < TOTAL_WORDS; phase++) random_phase(phase);

    settle();
    $display("Sent %0d words (%0d changed state) over %0d register settings;",
             words_sent, words_live, settings_used);
    $display("checked %0d selected entries, %0d enumerations run to the end, %0d mismatches.",
             sb.picks_checked, sb.runs_finished, sb.errors);
    if (sb.errors == 0 && sb.pending_picks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
